FILE: hdl/assert_macros.svh
// assertion macros shared by the poller rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CLHP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("poller assertion failed");
`define CLHP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("poller assertion failed");
`else
`define CLHP_ASSERT(lbl, clk, rst, prop)
`define CLHP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/clhp_pkg.sv
// types and constants of the channel link health poller
// no dependencies; used by the interfaces and all poller modules
`default_nettype none

package clhp_pkg;

  localparam int TIMEOUT_WIDTH = 16;
  localparam int COUNT_WIDTH   = 8;

  localparam int NUM_CH   = 3;
  localparam int CH_W     = 2;
  localparam int FLAG_W   = 6;
  localparam int PHASE_W  = 3;
  localparam int KIND_W   = 3;
  localparam int REQ_W    = 2;
  localparam int CMP_WIDTH = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_NR      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_NG      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NG_DETECT   = 3'd4;

  localparam logic [2:0]  RST_ENABLE_MASK = 3'd0;
  localparam logic [15:0] RST_TIMEOUT     = 16'd100;
  localparam logic [7:0]  RST_MAX_NR      = 8'd5;
  localparam logic [7:0]  RST_MAX_NG      = 8'd5;
  localparam logic        RST_NG_DETECT   = 1'b1;

  // request types
  localparam logic [REQ_W-1:0] REQ_TICK       = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REPORT     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLR_COUNTS = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLR_FLAGS  = 2'd3;

  // report kinds
  localparam logic [KIND_W-1:0] KIND_OVERCURRENT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NO_CURRENT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SOFT_OC     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OVERTEMP    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STATUS      = 3'd5;

  localparam logic [CH_W-1:0] CH_NONE = 2'd3;

  // poll phases
  localparam logic [PHASE_W-1:0] PH_ASK1   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CHECK  = 3'd6;
  localparam logic [PHASE_W-1:0] PH_UNUSED = 3'd7;

  // flag bit positions
  localparam logic [2:0] FLAG_NO_COMM  = 3'd4;
  localparam logic [2:0] FLAG_NO_TREAT = 3'd5;

  typedef struct packed {
    logic [2:0]  enable_mask;
    logic [15:0] reply_timeout_ticks;
    logic [7:0]  max_no_reply_errors;
    logic [7:0]  max_not_generating_errors;
    logic        not_generating_detect;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CH_W-1:0]   report_channel;
    logic [KIND_W-1:0] report_kind;
    logic              status_generating;
  } req_t;

  typedef struct packed {
    logic               poll_valid;
    logic [CH_W-1:0]    poll_channel;
    logic [PHASE_W-1:0] phase_now;
    logic [FLAG_W-1:0]  flags_ch1;
    logic [FLAG_W-1:0]  flags_ch2;
    logic [FLAG_W-1:0]  flags_ch3;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/clhp_in_if.sv
// request channel of the poller: valid/ready plus one decoded request
// depends on clhp_pkg
`default_nettype none

interface clhp_in_if;
  import clhp_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CH_W-1:0]   report_channel;
  logic [KIND_W-1:0] report_kind;
  logic              status_generating;

  modport source (output valid, req_type, report_channel, report_kind,
                  status_generating, input ready);
  modport sink (input valid, req_type, report_channel, report_kind,
                status_generating, output ready);
endinterface

`default_nettype wire

FILE: hdl/clhp_out_if.sv
// result channel of the poller: valid/ready plus poll and flag fields
// depends on clhp_pkg
`default_nettype none

interface clhp_out_if;
  import clhp_pkg::*;

  logic               valid;
  logic               ready;
  logic               poll_valid;
  logic [CH_W-1:0]    poll_channel;
  logic [PHASE_W-1:0] phase_now;
  logic [FLAG_W-1:0]  flags_ch1;
  logic [FLAG_W-1:0]  flags_ch2;
  logic [FLAG_W-1:0]  flags_ch3;

  modport source (output valid, poll_valid, poll_channel, phase_now,
                  flags_ch1, flags_ch2, flags_ch3, input ready);
  modport sink (input valid, poll_valid, poll_channel, phase_now,
                flags_ch1, flags_ch2, flags_ch3, output ready);
endinterface

`default_nettype wire

FILE: hdl/clhp_cfg_if.sv
// configuration write channel: valid/ready, register index and data
// depends on clhp_pkg
`default_nettype none

interface clhp_cfg_if;
  import clhp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/clhp_cfg_regs.sv
// configuration register file of the poller
// depends on clhp_pkg and clhp_cfg_if
`default_nettype none

module clhp_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  clhp_cfg_if.sink          cfg,
  output clhp_pkg::cfg_t    cfg_regs
);
  import clhp_pkg::*;

  cfg_t regs;

  assign cfg.ready = 1'b1;
  assign cfg_regs  = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enable_mask               <= RST_ENABLE_MASK;
      regs.reply_timeout_ticks       <= RST_TIMEOUT;
      regs.max_no_reply_errors       <= RST_MAX_NR;
      regs.max_not_generating_errors <= RST_MAX_NG;
      regs.not_generating_detect     <= RST_NG_DETECT;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_ENABLE_MASK: regs.enable_mask <= cfg.data[2:0];
        REG_TIMEOUT:     regs.reply_timeout_ticks <= cfg.data[15:0];
        REG_MAX_NR:      regs.max_no_reply_errors <= cfg.data[7:0];
        REG_MAX_NG:      regs.max_not_generating_errors <= cfg.data[7:0];
        REG_NG_DETECT:   regs.not_generating_detect <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/clhp_engine.sv
// poll state, counters and sticky flags with the single-step update logic
// depends on clhp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module clhp_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step_en,
  input  wire clhp_pkg::req_t item,
  input  wire clhp_pkg::cfg_t cfg_regs,
  output clhp_pkg::result_t   result
);
  import clhp_pkg::*;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  logic [PHASE_W-1:0]       phase, phase_next;
  logic [TIMEOUT_WIDTH-1:0] timeout_left, timeout_next;
  logic                     answered, answered_next;
  logic [COUNT_WIDTH-1:0]   nr_count [NUM_CH];
  logic [COUNT_WIDTH-1:0]   nr_next  [NUM_CH];
  logic [COUNT_WIDTH-1:0]   ng_count [NUM_CH];
  logic [COUNT_WIDTH-1:0]   ng_next  [NUM_CH];
  logic [FLAG_W-1:0]        flags    [NUM_CH];
  logic [FLAG_W-1:0]        flags_next [NUM_CH];
  logic                     poll;
  logic [CH_W-1:0]          poll_ch;
  logic [CH_W-1:0]          ph_ch;
  logic [CH_W-1:0]          rc;
  logic [2:0]               flag_bit;

  assign ph_ch    = phase[PHASE_W-1:1];
  assign rc       = item.report_channel;
  assign flag_bit = 3'(item.report_kind - KIND_OVERCURRENT);

  always_comb begin
    phase_next    = phase;
    timeout_next  = timeout_left;
    answered_next = answered;
    nr_next       = nr_count;
    ng_next       = ng_count;
    flags_next    = flags;
    poll          = 1'b0;
    poll_ch       = '0;
    unique case (item.req_type)
      REQ_TICK: begin
        if (phase == PH_CHECK) begin
          for (int c = 0; c < NUM_CH; c++) begin
            if (CMP_WIDTH'(nr_count[CH_W'(c)]) > CMP_WIDTH'(cfg_regs.max_no_reply_errors))
              flags_next[CH_W'(c)][FLAG_NO_COMM] = 1'b1;
            if (CMP_WIDTH'(ng_count[CH_W'(c)]) >
                CMP_WIDTH'(cfg_regs.max_not_generating_errors))
              flags_next[CH_W'(c)][FLAG_NO_TREAT] = 1'b1;
          end
          phase_next = PH_ASK1;
        end else if (phase == PH_UNUSED) begin
          phase_next = PH_ASK1;
        end else if (!phase[0]) begin
          // ask phase
          if (!cfg_regs.enable_mask[ph_ch]) begin
            phase_next = phase + PHASE_W'(2);
          end else begin
            answered_next = 1'b0;
            timeout_next  = TIMEOUT_WIDTH'(cfg_regs.reply_timeout_ticks);
            phase_next    = phase + PHASE_W'(1);
            poll          = 1'b1;
            poll_ch       = ph_ch;
          end
        end else if (timeout_left == '0) begin
          // wait phase closes
          nr_next[ph_ch] = answered ? '0 : sat_inc(nr_count[ph_ch]);
          phase_next     = phase + PHASE_W'(1);
        end
        if (timeout_next != '0)
          timeout_next = timeout_next - TIMEOUT_WIDTH'(1);
      end
      REQ_REPORT: begin
        if (rc != CH_NONE) begin
          case (item.report_kind) inside
            KIND_OVERCURRENT, KIND_NO_CURRENT, KIND_SOFT_OC, KIND_OVERTEMP:
              flags_next[rc][flag_bit] = 1'b1;
            KIND_STATUS: begin
              if (cfg_regs.not_generating_detect && !item.status_generating)
                ng_next[rc] = sat_inc(ng_count[rc]);
              answered_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      REQ_CLR_COUNTS: begin
        for (int c = 0; c < NUM_CH; c++) begin
          nr_next[CH_W'(c)] = '0;
          ng_next[CH_W'(c)] = '0;
        end
      end
      REQ_CLR_FLAGS: begin
        for (int c = 0; c < NUM_CH; c++)
          flags_next[CH_W'(c)] = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ASK1;
      timeout_left <= '0;
      answered     <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        nr_count[CH_W'(c)] <= '0;
        ng_count[CH_W'(c)] <= '0;
        flags[CH_W'(c)]    <= '0;
      end
    end else if (step_en) begin
      phase        <= phase_next;
      timeout_left <= timeout_next;
      answered     <= answered_next;
      nr_count     <= nr_next;
      ng_count     <= ng_next;
      flags        <= flags_next;
    end
  end

  assign result.poll_valid   = poll;
  assign result.poll_channel = poll_ch;
  assign result.phase_now    = phase_next;
  assign result.flags_ch1    = flags_next[0];
  assign result.flags_ch2    = flags_next[1];
  assign result.flags_ch3    = flags_next[2];

  // a running timeout only exists inside a wait phase
  `CLHP_ASSERT(a_timeout_in_wait, clk, rst, (timeout_left == '0) || phase[0])
  // the unused phase code is never reached
  `CLHP_ASSERT(a_phase_legal, clk, rst, phase != PH_UNUSED)
  // a clear-flags step leaves every flag low
  `CLHP_ASSERT_NEXT(a_clr_flags, clk, rst, step_en && item.req_type == REQ_CLR_FLAGS,
    flags[0] == '0 && flags[1] == '0 && flags[2] == '0)

endmodule

`default_nettype wire

FILE: hdl/channel_link_health_poller_core.sv
// top level of the channel link health poller
// path: a request transfer reaches the output through the input register and then the result register
// throughput: one request per cycle while the result register drains, since rsp.ready low stalls the engine step
// reset: synchronous active-high rst clears phase, timeout, counts, flags and the full bits of both pipe registers
// configuration registers return to their defaults on reset
// depends on clhp_pkg, the three channel interfaces, clhp_cfg_regs and clhp_engine
`default_nettype none
`include "assert_macros.svh"

module channel_link_health_poller_core (
  input  wire logic clk,
  input  wire logic rst,
  clhp_in_if.sink   req,
  clhp_out_if.source rsp,
  clhp_cfg_if.sink  cfg
);
  import clhp_pkg::*;

  // input register: holds one request until the result stage can take it
  logic    in_full;
  req_t    in_item;
  // result register: decouples the output handshake from the step logic
  logic    out_full;
  result_t out_item;

  cfg_t    cfg_regs;
  result_t step_result;
  logic    advance;

  // step the engine whenever a request is waiting and the result register is free
  // or being emptied in the same cycle
  assign advance   = in_full && (!out_full || rsp.ready);
  assign req.ready = !in_full || advance;

  clhp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_regs (cfg_regs)
  );

  clhp_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .step_en  (advance),
    .item     (in_item),
    .cfg_regs (cfg_regs),
    .result   (step_result)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // input payload, captured on every request transfer
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.req_type          <= req.req_type;
      in_item.report_channel    <= req.report_channel;
      in_item.report_kind       <= req.report_kind;
      in_item.status_generating <= req.status_generating;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (rsp.ready) begin
      out_full <= 1'b0;
    end
  end

  // result payload, loaded when the engine steps
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

  assign rsp.valid        = out_full;
  assign rsp.poll_valid   = out_item.poll_valid;
  assign rsp.poll_channel = out_item.poll_channel;
  assign rsp.phase_now    = out_item.phase_now;
  assign rsp.flags_ch1    = out_item.flags_ch1;
  assign rsp.flags_ch2    = out_item.flags_ch2;
  assign rsp.flags_ch3    = out_item.flags_ch3;

  // every engine step leaves a result waiting
  `CLHP_ASSERT_NEXT(a_step_fills_out, clk, rst, advance, out_full)
  // a poll always moves the phase into the matching wait phase
  `CLHP_ASSERT(a_poll_enters_wait, clk, rst,
    !(out_full && out_item.poll_valid) || out_item.phase_now[0])

endmodule

`default_nettype wire
